// ===== hw/rtl/ngs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types of the next greater element stack unit
// no dependencies

package ngs_pkg;

   // sequence and stack sizing
   localparam int MAX_LEN     = 64;
   localparam int DATA_W      = 32;
   localparam int POS_W       = 6;
   localparam int CNT_W       = $clog2(MAX_LEN + 1);
   localparam int ADDR_W      = $clog2(MAX_LEN);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified item handed from front to back
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     error;
      logic [POS_W-1:0]         position;
   } item_type;

   // one stack entry as held in the stack memory
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== hw/rtl/ngs_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and response transfers
// depends on ngs_pkg

interface ngs_req_if;
   import ngs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     last;

   modport source (output valid, value, last, input ready);
   modport sink (input valid, value, last, output ready);
endinterface

interface ngs_rsp_if;
   import ngs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] answer;
   logic                     found;
   logic                     error;
   logic                     run_end;

   modport source (output valid, position, answer, found, error, run_end, input ready);
   modport sink (input valid, position, answer, found, error, run_end, output ready);
endinterface

// ===== hw/rtl/ngs_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies

module ngs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ngs_queue.sv =====
`timescale 1ns / 1ps
// short item queue that decouples the front from the back
// depends on ngs_pkg

module ngs_queue import ngs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/ngs_front.sv =====
`timescale 1ns / 1ps
// front end: accepts request transfers, numbers them and flags overlong sequences
// depends on ngs_pkg, ngs_if

module ngs_front import ngs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ngs_req_if.sink  req_chan,
   output logic     push_valid,
   output item_type push_item,
   input  logic     push_ready
);

   logic [CNT_W-1:0] next_pos_ff, next_pos_in;
   logic             accept;
   logic             overflow;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign overflow       = (next_pos_ff >= CNT_W'(MAX_LEN));

   // classify the incoming element
   always_comb begin
      push_valid         = req_chan.valid;
      push_item.value    = req_chan.value;
      push_item.last     = req_chan.last;
      push_item.error    = overflow;
      push_item.position = overflow ? '0 : next_pos_ff[POS_W-1:0];
   end

   // position counter, cleared at the end of each sequence
   always_comb begin
      next_pos_in = next_pos_ff;
      if (accept) begin
         if (req_chan.last) begin
            next_pos_in = '0;
         end else if (!overflow) begin
            next_pos_in = next_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_pos_ff <= '0;
      end else begin
         next_pos_ff <= next_pos_in;
      end
   end

endmodule

// ===== hw/rtl/ngs_back.sv =====
`timescale 1ns / 1ps
// back end: monotonic stack sequencer over the stack ram, drives the response register
// depends on ngs_pkg, ngs_if, ngs_ram

module ngs_back import ngs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_ready,
   ngs_rsp_if.source rsp_chan
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_POP   = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   entry_type                top_ff, top_in;
   logic signed [DATA_W-1:0] cur_value_ff, cur_value_in;
   logic                     cur_last_ff, cur_last_in;
   logic [POS_W-1:0]         cur_pos_ff, cur_pos_in;
   logic [POS_W-1:0]         pop_pos_ff, pop_pos_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]         rsp_position_ff;
   logic signed [DATA_W-1:0] rsp_answer_ff;
   logic                     rsp_found_ff;
   logic                     rsp_error_ff;
   logic                     rsp_run_end_ff;

   logic                     emit;
   logic [POS_W-1:0]         res_position;
   logic signed [DATA_W-1:0] res_answer;
   logic                     res_found;
   logic                     res_error;
   logic                     res_run_end;

   logic                     out_free;
   logic                     load;
   logic                     step;
   logic                     top_less;
   logic                     rd_less;
   logic                     wr_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic [ENTRY_W-1:0]       rd_word;
   entry_type                rd_entry;
   entry_type                wr_entry;

   // stack storage
   ngs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LEN)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry       = entry_type'(rd_word);
   assign wr_entry.value    = cur_value_ff;
   assign wr_entry.position = cur_pos_ff;

   // read address tracks the top entry, the one below it when a pop moves on
   assign rd_addr = cnt_ff[ADDR_W-1:0] - ADDR_W'(1) - ADDR_W'(step);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign top_less = (cnt_ff != '0) && (top_ff.value < cur_value_ff);
   assign rd_less  = (cnt_ff != '0) && (rd_entry.value < cur_value_ff);
   assign load     = emit && out_free;

   // stack sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      cur_value_in = cur_value_ff;
      cur_last_in  = cur_last_ff;
      cur_pos_in   = cur_pos_ff;
      pop_pos_in   = pop_pos_ff;
      q_ready      = 1'b0;
      step         = 1'b0;
      wr_en        = 1'b0;
      emit         = 1'b0;
      res_position = '0;
      res_answer   = '0;
      res_found    = 1'b0;
      res_error    = 1'b0;
      res_run_end  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_item.error) begin
                  // dropped element gives a single error result
                  emit        = 1'b1;
                  res_error   = 1'b1;
                  res_run_end = 1'b1;
                  if (out_free) begin
                     q_ready = 1'b1;
                     if (q_item.last) begin
                        cnt_in = '0;
                     end
                  end
               end else begin
                  q_ready      = 1'b1;
                  cur_value_in = q_item.value;
                  cur_last_in  = q_item.last;
                  cur_pos_in   = q_item.position;
                  state_in     = S_CMP;
               end
            end
         end
         S_CMP: begin
            if (top_less) begin
               // first pop: take the top, fetch the entry below
               step       = 1'b1;
               cnt_in     = cnt_ff - 1'b1;
               pop_pos_in = top_ff.position;
               state_in   = S_POP;
            end else if (!cur_last_ff) begin
               // push the element and finish
               if (cnt_ff < CNT_W'(MAX_LEN)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  top_in = wr_entry;
               end
               state_in = S_IDLE;
            end else begin
               // last element reports itself first, unpushed
               emit         = 1'b1;
               res_position = cur_pos_ff;
               res_run_end  = (cnt_ff == '0);
               if (out_free) begin
                  state_in = (cnt_ff == '0) ? S_IDLE : S_FLUSH;
               end
            end
         end
         S_POP: begin
            // report the popped entry, decide on the next from the fetched one
            emit         = 1'b1;
            res_position = pop_pos_ff;
            res_answer   = cur_value_ff;
            res_found    = 1'b1;
            res_run_end  = !cur_last_ff && !rd_less;
            if (out_free) begin
               if (cnt_ff != '0) begin
                  top_in = rd_entry;
               end
               if (rd_less) begin
                  step       = 1'b1;
                  cnt_in     = cnt_ff - 1'b1;
                  pop_pos_in = rd_entry.position;
               end else begin
                  state_in = S_CMP;
               end
            end
         end
         S_FLUSH: begin
            // drain the remaining entries without a greater value
            emit         = 1'b1;
            res_position = rd_entry.position;
            res_run_end  = (cnt_ff == CNT_W'(1));
            if (out_free) begin
               step   = 1'b1;
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      cur_value_ff <= cur_value_in;
      cur_last_ff  <= cur_last_in;
      cur_pos_ff   <= cur_pos_in;
      pop_pos_ff   <= pop_pos_in;
   end

   // response register
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_position_ff <= res_position;
         rsp_answer_ff   <= res_answer;
         rsp_found_ff    <= res_found;
         rsp_error_ff    <= res_error;
         rsp_run_end_ff  <= res_run_end;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.position = rsp_position_ff;
   assign rsp_chan.answer   = rsp_answer_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.error    = rsp_error_ff;
   assign rsp_chan.run_end  = rsp_run_end_ff;

`ifndef SYNTH
   // stack never grows past its depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_LEN))
      else $error("stack count beyond depth");

   // flush only runs with entries left
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |-> cnt_ff != '0)
      else $error("flush with empty stack");

   // the final flush transfer leaves the stack empty and idle
   a_flush_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && out_free && cnt_ff == CNT_W'(1))
      |=> (cnt_ff == '0 && state_ff == S_IDLE))
      else $error("flush did not clear the stack");

   // pushes only happen for a non-last element in the compare step
   a_push_ctx: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CMP && !cur_last_ff))
      else $error("stack write outside push");

   // an error result closes its run and carries no answer
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (load && res_error) |=> (rsp_run_end_ff && !rsp_found_ff && rsp_answer_ff == '0))
      else $error("malformed error result");
`endif

endmodule

// ===== hw/rtl/next_greater_element_stack_unit.sv =====
`timescale 1ns / 1ps
// first result: a dropped element is reported from the idle state, a last element that pops
//   nothing from the compare state, an element that pops from the pop state (plus queue and stall wait)
// sequencing: each element passes idle and compare, then pop once per popped entry and flush
//   once per flushed entry on the last element; a dropped element is handled in idle alone
// reset: synchronous, clears counters, queue and response valid; requests taken at once
// depends on ngs_pkg, ngs_if, ngs_queue, ngs_front, ngs_back

module next_greater_element_stack_unit import ngs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ngs_req_if.sink   req_chan,
   ngs_rsp_if.source rsp_chan
);

   logic     push_valid;
   item_type push_item;
   logic     push_ready;
   logic     pop_valid;
   item_type pop_item;
   logic     pop_ready;

   // numbering and classification
   ngs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // decoupling queue
   ngs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // stack processing and response
   ngs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (pop_valid),
      .q_item   (pop_item),
      .q_ready  (pop_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for next_greater_element_stack_unit: directed and random sequences
// depends on ngs_pkg, ngs_if and the unit's rtl

module tb_top import ngs_pkg::*; ();

   localparam int CYCLE_LIMIT  = 300000;
   localparam int ITEM_TARGET  = 160;
   localparam int SETTLE       = 20;

   localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] answer;
      logic                     found;
      logic                     error;
      logic                     run_end;
   } answer_type;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_HOLD} stall_mode_type;
   typedef enum int {SEQ_MIXED, SEQ_FALLING, SEQ_NARROW} seq_style_type;

   // predicts next greater answers and holds them until the unit reports them
   class answer_board;
      logic signed [DATA_W-1:0] stack_value [MAX_LEN];
      logic [POS_W-1:0]         stack_pos [MAX_LEN];
      int                       depth;
      int                       next_pos;
      answer_type               expected [$];
      answer_type               held;
      bit                       holding;
      int                       mismatches;

      function new();
         depth      = 0;
         next_pos   = 0;
         holding    = 1'b0;
         mismatches = 0;
      endfunction

      // queue the previous answer, keep this one until we know if it ends the batch
      function void stage(logic [POS_W-1:0] p, logic signed [DATA_W-1:0] a, logic f, logic e);
         if (holding) expected.insert(expected.size(), held);
         held.position = p;
         held.answer   = a;
         held.found    = f;
         held.error    = e;
         held.run_end  = 1'b0;
         holding       = 1'b1;
      endfunction

      // an accepted element: pop smaller entries, push, flush on the last one
      function void note_element(logic signed [DATA_W-1:0] v, logic is_last);
         if (next_pos >= MAX_LEN) begin
            // beyond the sequence limit: one error answer, dropped
            stage('0, '0, 1'b0, 1'b1);
            if (is_last) begin
               depth    = 0;
               next_pos = 0;
            end
         end else begin
            while (depth > 0 && stack_value[depth-1] < v) begin
               depth--;
               stage(stack_pos[depth], v, 1'b1, 1'b0);
            end
            if (depth < MAX_LEN) begin
               stack_value[depth] = v;
               stack_pos[depth]   = POS_W'(next_pos);
               depth++;
            end
            next_pos++;
            if (is_last) begin
               while (depth > 0) begin
                  depth--;
                  stage(stack_pos[depth], '0, 1'b0, 1'b0);
               end
               next_pos = 0;
            end
         end
         if (holding) begin
            held.run_end = 1'b1;
            expected.insert(expected.size(), held);
            holding = 1'b0;
         end
      endfunction

      function void report(string what, answer_type want, answer_type got);
         mismatches++;
         if (mismatches <= 10)
            $display({"%t %s: want pos %0d ans %0d fnd %0b err %0b end %0b,",
                      " got pos %0d ans %0d fnd %0b err %0b end %0b"},
                     $realtime, what, want.position, want.answer, want.found, want.error,
                     want.run_end, got.position, got.answer, got.found, got.error,
                     got.run_end);
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (expected.size() == 0) begin
            report("unexpected result", '0, got);
         end else begin
            want = expected.pop_front();
            if (got.position !== want.position || got.answer !== want.answer ||
                got.found !== want.found || got.error !== want.error ||
                got.run_end !== want.run_end)
               report("wrong result", want, got);
         end
      endfunction

      function void finish_check();
         while (expected.size() > 0)
            report("missing result", expected.pop_front(), '0);
      endfunction

      function int outstanding();
         return expected.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   ngs_req_if   req_bus ();
   ngs_rsp_if   rsp_bus ();
   answer_board board;
   answer_type  seen;
   int          items_sent;
   int          burst_left;
   int          cycle_count;

   next_greater_element_stack_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result monitor, checks every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.position = rsp_bus.position;
         seen.answer   = rsp_bus.answer;
         seen.found    = rsp_bus.found;
         seen.error    = rsp_bus.error;
         seen.run_end  = rsp_bus.run_end;
         board.check_answer(seen);
      end
   end

   // receiver back-pressure, in stall modes chosen at random over random spans
   initial begin
      stall_mode_type mode;
      int             span;
      int             phase;
      logic [7:0]     pattern;
      rsp_bus.ready = 1'b0;
      mode    = STALL_NONE;
      span    = 0;
      phase   = 0;
      pattern = 8'hff;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            mode    = stall_mode_type'($urandom_range(0, 3));
            span    = (mode == STALL_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
            pattern = $urandom;
         end
         span--;
         case (mode)
            STALL_NONE:    rsp_bus.ready = 1'b1;
            STALL_COIN:    rsp_bus.ready = ($urandom_range(0, 2) != 0);
            STALL_PATTERN: begin
               rsp_bus.ready = pattern[phase % 8];
               phase++;
            end
            default:       rsp_bus.ready = 1'b0;
         endcase
      end
   end

   // one element transfer, with bursts and random gaps on the sender side
   task automatic send_element(input logic signed [DATA_W-1:0] v, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = $urandom_range(0, 5);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.value = v;
      req_bus.last  = is_last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_element(v, is_last);
      items_sent++;
   endtask

   // hold the sender off until every predicted answer has come back
   task automatic drain_answers();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value(seq_style_type style);
      logic signed [DATA_W-1:0] v;
      if (style == SEQ_NARROW) begin
         v = $signed(DATA_W'($urandom_range(0, 6))) - 3;
      end else begin
         case ($urandom_range(0, 7))
            0:       v = MOST_NEG;
            1:       v = MOST_POS;
            2, 3:    v = $signed(DATA_W'($urandom_range(0, 8))) - 4;
            default: v = $urandom;
         endcase
      end
      return v;
   endfunction

   // one sequence, the final element marked last
   task automatic run_sequence(input int len, input seq_style_type style);
      logic signed [DATA_W-1:0] v;
      logic signed [DATA_W-1:0] prev;
      prev = MOST_POS;
      for (int i = 0; i < len; i++) begin
         if (style == SEQ_FALLING) begin
            v    = (i == len - 1) ? MOST_NEG : prev - DATA_W'($urandom_range(0, 1000));
            prev = v;
         end else begin
            v = pick_value(style);
         end
         send_element(v, i == len - 1);
      end
   endtask

   // stimulus
   initial begin
      int kind;
      bit paused;
      board         = new();
      items_sent    = 0;
      burst_left    = 0;
      paused        = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      req_bus.last  = 1'b0;
      reset         = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single element sequence
      send_element(0, 1'b1);
      // extremes: most negative popped by most positive
      send_element(MOST_NEG, 1'b0);
      send_element(MOST_POS, 1'b1);
      // equal values never pop each other
      send_element(5, 1'b0);
      send_element(5, 1'b0);
      send_element(5, 1'b1);
      // falling run popped at once by the last element
      send_element(3, 1'b0);
      send_element(2, 1'b0);
      send_element(1, 1'b0);
      send_element(10, 1'b1);
      // negative values and partial pops
      send_element(-1, 1'b0);
      send_element(-2, 1'b0);
      send_element(0, 1'b0);
      send_element(MOST_POS, 1'b0);
      send_element(MOST_NEG, 1'b0);
      send_element(-7, 1'b1);
      // repeated maximum, then a minimum popped by the last element
      send_element(MOST_POS, 1'b0);
      send_element(MOST_POS, 1'b0);
      send_element(MOST_NEG, 1'b0);
      send_element(0, 1'b1);
      drain_answers();

      // falling sequence of the maximum length, its stack flushed by the last element
      run_sequence(MAX_LEN, SEQ_FALLING);
      // overrun of the sequence limit, error results then clear on last
      run_sequence(MAX_LEN + $urandom_range(1, 4), SEQ_MIXED);

      // short sequences with random content up to the item target
      while (items_sent < ITEM_TARGET) begin
         if (!paused && items_sent >= ITEM_TARGET - 5) begin
            drain_answers();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 9);
         if (kind <= 5)
            run_sequence($urandom_range(1, 8), SEQ_MIXED);
         else if (kind <= 7)
            run_sequence($urandom_range(9, 24), SEQ_MIXED);
         else if (kind == 8)
            run_sequence($urandom_range(2, 12), SEQ_FALLING);
         else
            run_sequence($urandom_range(2, 10), SEQ_NARROW);
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      board.finish_check();
      if (board.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
